### rtl/complex_arithmetic_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit.
// With SYNTH defined the macros expand to nothing.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is high.
`define CAU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("complex arithmetic unit check failed");

// Clocked check without a disable term; the property handles reset itself.
`define CAU_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("complex arithmetic unit check failed");

`else

`define CAU_ASSERT(lbl, clk, rst, prop)
`define CAU_ASSERT_NR(lbl, clk, prop)

`endif

`endif

### rtl/cau_pkg.sv
package cau_pkg;

   // Operand and result format.
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Internal widths: full products, their sums, and shifted numerators.
   localparam int PROD_W   = 2 * DATA_WIDTH;
   localparam int WIDE_W   = PROD_W + 1;
   localparam int NUM_W    = PROD_W + FRAC_BITS;
   localparam int SQ_REM_W = DATA_WIDTH + 2;

   // One quotient bit and one root bit are resolved per iteration stage.
   localparam int STEPS = DATA_WIDTH;

   // Operation codes.
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MAG = 3'd4;

   // Limits of the signed result range and the rounding constant for multiply.
   localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [2:0]                   action;
      logic signed [DATA_WIDTH-1:0] a_real;
      logic signed [DATA_WIDTH-1:0] a_imag;
      logic signed [DATA_WIDTH-1:0] b_real;
      logic signed [DATA_WIDTH-1:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_real;
      logic signed [DATA_WIDTH-1:0] result_imag;
      logic                         div_by_zero;
      logic                         saturated;
   } rsp_type;

   // Clipped value together with its saturation flag.
   typedef struct packed {
      logic                         sat;
      logic signed [DATA_WIDTH-1:0] value;
   } clip_type;

   // One division lane: partial remainder, and a word that holds the
   // unconsumed low numerator bits on top and the quotient bits below.
   typedef struct packed {
      logic [PROD_W-1:0]     rem;
      logic [DATA_WIDTH-1:0] nq;
      logic                  neg;
      logic                  ovf;
   } div_lane_type;

   // Everything that travels down the iteration pipeline.
   typedef struct packed {
      logic                         vld;
      logic [2:0]                   op;
      logic                         dz;
      logic signed [DATA_WIDTH-1:0] pre_real;
      logic signed [DATA_WIDTH-1:0] pre_imag;
      logic                         pre_sat;
      logic [PROD_W-1:0]            den;
      div_lane_type                 lane_re;
      div_lane_type                 lane_im;
      logic [PROD_W-1:0]            rad;
      logic [SQ_REM_W-1:0]          sq_rem;
      logic [DATA_WIDTH-1:0]        root;
   } step_type;

   // Clip a wide signed value to the result range.
   function automatic clip_type clip_wide(input logic signed [WIDE_W-1:0] v);
      clip_type c;
      c.sat   = 1'b0;
      c.value = v[DATA_WIDTH-1:0];
      if (!(&v[WIDE_W-1:DATA_WIDTH-1]) && (|v[WIDE_W-1:DATA_WIDTH-1])) begin
         c.sat   = 1'b1;
         c.value = v[WIDE_W-1] ? MIN_VAL : MAX_VAL;
      end
      return c;
   endfunction

endpackage

### rtl/cau_front.sv
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              req_valid,
   input  cau_pkg::req_type  req_data,
   output cau_pkg::step_type step_out
);
   import cau_pkg::*;

   typedef struct packed {
      logic                     vld;
      logic [2:0]               op;
      logic signed [PROD_W-1:0] p_rr;
      logic signed [PROD_W-1:0] p_ii;
      logic signed [PROD_W-1:0] p_ri;
      logic signed [PROD_W-1:0] p_ir;
      logic signed [PROD_W-1:0] p_x;
      logic signed [PROD_W-1:0] p_y;
      logic signed [DATA_WIDTH:0] s_re;
      logic signed [DATA_WIDTH:0] s_im;
   } s1_type;

   typedef struct packed {
      logic                     vld;
      logic [2:0]               op;
      logic signed [WIDE_W-1:0] x_re;
      logic signed [WIDE_W-1:0] x_im;
      logic [PROD_W-1:0]        sq;
   } s2_type;

   typedef struct packed {
      logic                         vld;
      logic [2:0]                   op;
      logic                         dz;
      logic signed [DATA_WIDTH-1:0] pre_real;
      logic signed [DATA_WIDTH-1:0] pre_imag;
      logic                         pre_sat;
      logic [PROD_W-1:0]            mag_re;
      logic [PROD_W-1:0]            mag_im;
      logic                         neg_re;
      logic                         neg_im;
      logic [PROD_W-1:0]            sq;
   } s3_type;

   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   step_type s4_ff, s4_in;

   logic signed [DATA_WIDTH-1:0] sq_a, sq_b;
   logic signed [WIDE_W-1:0]     r_re, r_im, n_re, n_im;
   clip_type                     c_re, c_im;
   logic [NUM_W-1:0]             num_re, num_im;

   // Stage 1: the six products and the add or subtract sums.
   always_comb begin
      sq_a = (req_data.action == OP_MAG) ? req_data.a_real : req_data.b_real;
      sq_b = (req_data.action == OP_MAG) ? req_data.a_imag : req_data.b_imag;
      s1_in.vld  = req_valid;
      s1_in.op   = req_data.action;
      s1_in.p_rr = req_data.a_real * req_data.b_real;
      s1_in.p_ii = req_data.a_imag * req_data.b_imag;
      s1_in.p_ri = req_data.a_real * req_data.b_imag;
      s1_in.p_ir = req_data.a_imag * req_data.b_real;
      s1_in.p_x  = sq_a * sq_a;
      s1_in.p_y  = sq_b * sq_b;
      if (req_data.action == OP_SUB) begin
         s1_in.s_re = (DATA_WIDTH+1)'(req_data.a_real) - (DATA_WIDTH+1)'(req_data.b_real);
         s1_in.s_im = (DATA_WIDTH+1)'(req_data.a_imag) - (DATA_WIDTH+1)'(req_data.b_imag);
      end else begin
         s1_in.s_re = (DATA_WIDTH+1)'(req_data.a_real) + (DATA_WIDTH+1)'(req_data.b_real);
         s1_in.s_im = (DATA_WIDTH+1)'(req_data.a_imag) + (DATA_WIDTH+1)'(req_data.b_imag);
      end
   end

   // Stage 2: form the real and imaginary parts (sums, products or numerators) and the squared norm.
   always_comb begin
      s2_in.vld = s1_ff.vld;
      s2_in.op  = s1_ff.op;
      s2_in.sq  = $unsigned(s1_ff.p_x) + $unsigned(s1_ff.p_y);
      case (s1_ff.op)
         OP_ADD, OP_SUB: begin
            s2_in.x_re = WIDE_W'(s1_ff.s_re);
            s2_in.x_im = WIDE_W'(s1_ff.s_im);
         end
         OP_MUL: begin
            s2_in.x_re = WIDE_W'(s1_ff.p_rr) - WIDE_W'(s1_ff.p_ii);
            s2_in.x_im = WIDE_W'(s1_ff.p_ri) + WIDE_W'(s1_ff.p_ir);
         end
         OP_DIV: begin
            s2_in.x_re = WIDE_W'(s1_ff.p_rr) + WIDE_W'(s1_ff.p_ii);
            s2_in.x_im = WIDE_W'(s1_ff.p_ir) - WIDE_W'(s1_ff.p_ri);
         end
         default: begin
            s2_in.x_re = '0;
            s2_in.x_im = '0;
         end
      endcase
   end

   // Stage 3: clip add and subtract, round and clip multiply; split numerators
   // into sign and magnitude for the divider.
   always_comb begin
      r_re = (s2_ff.x_re + HALF) >>> FRAC_BITS;
      r_im = (s2_ff.x_im + HALF) >>> FRAC_BITS;
      n_re = -s2_ff.x_re;
      n_im = -s2_ff.x_im;
      case (s2_ff.op)
         OP_ADD, OP_SUB: begin
            c_re = clip_wide(s2_ff.x_re);
            c_im = clip_wide(s2_ff.x_im);
         end
         OP_MUL: begin
            c_re = clip_wide(r_re);
            c_im = clip_wide(r_im);
         end
         default: begin
            c_re = '0;
            c_im = '0;
         end
      endcase
      s3_in.vld      = s2_ff.vld;
      s3_in.op       = s2_ff.op;
      s3_in.dz       = (s2_ff.sq == '0);
      s3_in.pre_real = c_re.value;
      s3_in.pre_imag = c_im.value;
      s3_in.pre_sat  = c_re.sat | c_im.sat;
      s3_in.neg_re   = s2_ff.x_re[WIDE_W-1];
      s3_in.neg_im   = s2_ff.x_im[WIDE_W-1];
      s3_in.mag_re   = s2_ff.x_re[WIDE_W-1] ? n_re[PROD_W-1:0] : s2_ff.x_re[PROD_W-1:0];
      s3_in.mag_im   = s2_ff.x_im[WIDE_W-1] ? n_im[PROD_W-1:0] : s2_ff.x_im[PROD_W-1:0];
      s3_in.sq       = s2_ff.sq;
   end

   // Stage 4: scale numerators, detect quotients beyond the result width,
   // and seed the divider and square root iterations.
   always_comb begin
      num_re = {s3_ff.mag_re, {FRAC_BITS{1'b0}}};
      num_im = {s3_ff.mag_im, {FRAC_BITS{1'b0}}};
      s4_in.vld          = s3_ff.vld;
      s4_in.op           = s3_ff.op;
      s4_in.dz           = s3_ff.dz;
      s4_in.pre_real     = s3_ff.pre_real;
      s4_in.pre_imag     = s3_ff.pre_imag;
      s4_in.pre_sat      = s3_ff.pre_sat;
      s4_in.den          = s3_ff.sq;
      s4_in.lane_re.rem  = PROD_W'(num_re[NUM_W-1:DATA_WIDTH]);
      s4_in.lane_re.nq   = num_re[DATA_WIDTH-1:0];
      s4_in.lane_re.neg  = s3_ff.neg_re;
      s4_in.lane_re.ovf  = PROD_W'(num_re[NUM_W-1:DATA_WIDTH]) >= s3_ff.sq;
      s4_in.lane_im.rem  = PROD_W'(num_im[NUM_W-1:DATA_WIDTH]);
      s4_in.lane_im.nq   = num_im[DATA_WIDTH-1:0];
      s4_in.lane_im.neg  = s3_ff.neg_im;
      s4_in.lane_im.ovf  = PROD_W'(num_im[NUM_W-1:DATA_WIDTH]) >= s3_ff.sq;
      s4_in.rad          = s3_ff.sq;
      s4_in.sq_rem       = '0;
      s4_in.root         = '0;
   end

   // Stage registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0;
         s4_ff.vld <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign step_out = s4_ff;

endmodule

### rtl/cau_step.sv
module cau_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  cau_pkg::step_type prev_stage,
   output cau_pkg::step_type stage_out
);
   import cau_pkg::*;

   step_type stage_ff, stage_in;

   logic [SQ_REM_W+1:0] t_sq;
   logic [SQ_REM_W+1:0] trial;

   // One restoring division step: bring down the next numerator bit and
   // subtract the denominator when it fits.
   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [PROD_W-1:0] den);
      logic [PROD_W:0] t;
      logic [PROD_W:0] d;
      div_lane_type    r;
      t = {l.rem, l.nq[DATA_WIDTH-1]};
      d = {1'b0, den};
      r = l;
      if (t >= d) begin
         r.rem = PROD_W'(t - d);
         r.nq  = {l.nq[DATA_WIDTH-2:0], 1'b1};
      end else begin
         r.rem = t[PROD_W-1:0];
         r.nq  = {l.nq[DATA_WIDTH-2:0], 1'b0};
      end
      return r;
   endfunction

   // Both division lanes and one digit-by-digit square root step.
   always_comb begin
      stage_in         = prev_stage;
      stage_in.lane_re = div_step(prev_stage.lane_re, prev_stage.den);
      stage_in.lane_im = div_step(prev_stage.lane_im, prev_stage.den);
      t_sq  = {prev_stage.sq_rem, prev_stage.rad[PROD_W-1 -: 2]};
      trial = {2'b00, prev_stage.root, 2'b01};
      stage_in.rad = prev_stage.rad << 2;
      if (t_sq >= trial) begin
         stage_in.sq_rem = SQ_REM_W'(t_sq - trial);
         stage_in.root   = {prev_stage.root[DATA_WIDTH-2:0], 1'b1};
      end else begin
         stage_in.sq_rem = t_sq[SQ_REM_W-1:0];
         stage_in.root   = {prev_stage.root[DATA_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

### rtl/cau_back.sv
`include "complex_arithmetic_unit_defines.svh"

module cau_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  cau_pkg::step_type last,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output cau_pkg::rsp_type  rsp_data,
   output logic              hold
);
   import cau_pkg::*;

   rsp_type  result;
   clip_type q_re, q_im;
   logic     take;

   logic    out_vld_ff, out_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;

   // Sign and clip a quotient; ovf means it did not fit the result width.
   function automatic clip_type quo_clip(input div_lane_type l);
      clip_type c;
      c.sat   = 1'b0;
      c.value = '0;
      if (l.ovf) begin
         c.sat   = 1'b1;
         c.value = l.neg ? MIN_VAL : MAX_VAL;
      end else if (!l.neg) begin
         if (l.nq[DATA_WIDTH-1]) begin
            c.sat   = 1'b1;
            c.value = MAX_VAL;
         end else begin
            c.value = $signed(l.nq);
         end
      end else begin
         if (l.nq[DATA_WIDTH-1] && (|l.nq[DATA_WIDTH-2:0])) begin
            c.sat   = 1'b1;
            c.value = MIN_VAL;
         end else begin
            c.value = -$signed(l.nq);
         end
      end
      return c;
   endfunction

   // Final result selection per operation.
   always_comb begin
      q_re   = quo_clip(last.lane_re);
      q_im   = quo_clip(last.lane_im);
      result = '0;
      case (last.op)
         OP_ADD, OP_SUB, OP_MUL: begin
            result.result_real = last.pre_real;
            result.result_imag = last.pre_imag;
            result.saturated   = last.pre_sat;
         end
         OP_DIV: begin
            if (last.dz) begin
               result.div_by_zero = 1'b1;
            end else begin
               result.result_real = q_re.value;
               result.result_imag = q_im.value;
               result.saturated   = q_re.sat | q_im.sat;
            end
         end
         OP_MAG: begin
            if (last.root[DATA_WIDTH-1]) begin
               result.result_real = MAX_VAL;
               result.saturated   = 1'b1;
            end else begin
               result.result_real = $signed(last.root);
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // Output register with a one-entry skid; a full skid freezes the pipeline.
   always_comb begin
      take         = last.vld && en;
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (!out_vld_ff || !rsp_stall) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = take;
            out_data_in = result;
         end
      end else if (take) begin
         skid_vld_in  = 1'b1;
         skid_data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;
   assign hold      = skid_vld_ff;

   // The skid only holds a transaction while the output register is full.
   `CAU_ASSERT(a_skid_needs_out, clock, reset, skid_vld_ff |-> out_vld_ff)
   // The skid fills only behind a stalled output.
   `CAU_ASSERT(a_skid_fill, clock, reset, $rose(skid_vld_ff) |-> $past(out_vld_ff && rsp_stall))
   // A zero denominator always delivers a clean zero result.
   `CAU_ASSERT_NR(a_dz_zero, clock, reset || !(out_vld_ff && out_data_ff.div_by_zero) || (out_data_ff.result_real == '0 && out_data_ff.result_imag == '0 && !out_data_ff.saturated))

endmodule

### rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed Q16.16 operands.
// The request channel (req_valid, req_stall, req_data) carries one operation
// code and two complex operands per transaction: add, subtract, multiply,
// divide, or magnitude of the first operand. The response channel (rsp_valid,
// rsp_stall, rsp_data) returns one result per request, in request order,
// with a divide-by-zero flag and a saturation flag.
// From request acceptance to rsp_valid a transaction passes four front
// stages (products, sums, rounding and clipping, divider setup), 32 iteration
// stages that each resolve one quotient bit per divide lane and one square
// root bit, and the output register.
// Throughput is one transaction per cycle while req_stall is low; every
// operation goes through the same pipeline.
// Reset clears all valid bits; the block accepts requests on the first cycle
// after reset. When the receiver stalls, one more result is caught in a skid
// register, then req_stall rises and the whole pipeline holds until the
// receiver takes the waiting result.
module complex_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   logic     en;
   logic     hold;
   step_type chain [STEPS+1];

   assign en        = !hold;
   assign req_stall = hold;

   // Multiply, combine and divider setup.
   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_data  (req_data),
      .step_out  (chain[0])
   );

   // Divide and square root iterations, one result bit per stage.
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      cau_step u_step (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .prev_stage (chain[g]),
         .stage_out  (chain[g+1])
      );
   end

   // Result selection, clipping and output buffering.
   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .last      (chain[STEPS]),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .hold      (hold)
   );

endmodule
